### rtl/core/spq_pkg.sv
// spq_pkg: shared types and codes for the stable priority queue.
// Used by spq_ctrl, spq_dp, stable_priority_queue and spq_chk.
package spq_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_POP    = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic step;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic rem_scan;
    logic scan_last;
  } sts_t;

endpackage

### rtl/core/spq_ctrl.sv
// spq_ctrl: command sequencer of the stable priority queue.
// Depends on spq_pkg; drives spq_dp through ctl_t, reads sts_t.
module spq_ctrl
  import spq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = sts.rem_scan ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        if (sts.scan_last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy     = (state != S_IDLE);
    ctl.load = (state == S_IDLE) && start;
    ctl.exec = (state == S_EXEC);
    ctl.step = (state == S_SCAN);
  end

endmodule

### rtl/core/spq_dp.sv
// spq_dp: sorted row of entry cells, operand and result registers.
// Depends on spq_pkg; sequenced by spq_ctrl.
module spq_dp
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  ctl_t        ctl,
  input  logic [1:0]  cmd,
  input  logic [15:0] doc_id,
  input  logic [7:0]  prio,
  output sts_t        sts,
  output logic        done,
  output logic [1:0]  status_code,
  output logic [15:0] out_id,
  output logic [7:0]  out_prio,
  output logic [4:0]  occupancy
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);

  logic [15:0] ids [QUEUE_DEPTH];
  logic [7:0]  prios [QUEUE_DEPTH];
  logic [15:0] ids_next [QUEUE_DEPTH];
  logic [7:0]  prios_next [QUEUE_DEPTH];
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] scan_left, scan_left_next;
  logic removed, removed_next;
  cmd_t rcmd;
  logic [15:0] rid;
  logic [7:0]  rprio;

  logic [QUEUE_DEPTH-1:0] valid, gt, gt_prev, match;
  logic hit, full, empty, keep, fin;
  logic [CW-1:0] tail;
  status_t st_next;
  logic [15:0] oid_next;
  logic [7:0]  opr_next;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      valid[i] = CW'(i) < count;
      gt[i]    = valid[i] && (prios[i] > rprio);
      match[i] = valid[i] && (ids[i] == rid);
    end
  end

  assign gt_prev = {gt[QUEUE_DEPTH-2:0], 1'b0};
  assign hit     = |match;
  assign full    = (count == CW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign keep    = (ids[0] != rid);
  assign tail    = count - CW'(1);

  assign sts.rem_scan  = (rcmd == CMD_REMOVE) && !empty;
  assign sts.scan_last = (scan_left == CW'(1));

  always_comb begin
    ids_next       = ids;
    prios_next     = prios;
    count_next     = count;
    scan_left_next = scan_left;
    removed_next   = removed;
    fin            = 1'b0;
    st_next        = ST_OK;
    oid_next       = '0;
    opr_next       = '0;
    if (ctl.exec) begin
      unique case (rcmd)
        CMD_INSERT: begin
          fin = 1'b1;
          if (full) begin
            st_next = ST_FULL;
          end else begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
              if (gt_prev[i]) begin
                ids_next[i]   = ids[(i == 0) ? 0 : i - 1];
                prios_next[i] = prios[(i == 0) ? 0 : i - 1];
              end else if (gt[i] || (CW'(i) == count)) begin
                ids_next[i]   = rid;
                prios_next[i] = rprio;
              end
            end
            count_next = count + CW'(1);
          end
        end
        CMD_POP: begin
          fin = 1'b1;
          if (empty) begin
            st_next = ST_EMPTY;
          end else begin
            oid_next = ids[0];
            opr_next = prios[0];
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
              ids_next[i]   = ids[i + 1];
              prios_next[i] = prios[i + 1];
            end
            count_next = count - CW'(1);
          end
        end
        CMD_QUERY: begin
          fin     = 1'b1;
          st_next = hit ? ST_OK : ST_NOTFOUND;
        end
        CMD_REMOVE: begin
          if (empty) begin
            fin     = 1'b1;
            st_next = ST_NOTFOUND;
          end else begin
            scan_left_next = count;
            removed_next   = 1'b0;
          end
        end
        default: fin = 1'b1;
      endcase
    end else if (ctl.step) begin
      // rotate head to tail, dropping it on an id match
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        ids_next[i]   = ids[i + 1];
        prios_next[i] = prios[i + 1];
      end
      if (keep) begin
        ids_next[tail[IW-1:0]]   = ids[0];
        prios_next[tail[IW-1:0]] = prios[0];
      end else begin
        count_next = count - CW'(1);
      end
      removed_next   = removed || !keep;
      scan_left_next = scan_left - CW'(1);
      if (sts.scan_last) begin
        fin     = 1'b1;
        st_next = removed_next ? ST_OK : ST_NOTFOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    ids       <= ids_next;
    prios     <= prios_next;
    scan_left <= scan_left_next;
    removed   <= removed_next;
    if (ctl.load) begin
      rcmd  <= cmd_t'(cmd);
      rid   <= doc_id;
      rprio <= prio;
    end
    if (fin) begin
      status_code <= st_next;
      out_id      <= oid_next;
      out_prio    <= opr_next;
    end
  end

  assign occupancy = 5'(count);

endmodule

### rtl/core/stable_priority_queue.sv
// stable_priority_queue: top level, controller plus cell-row datapath.
// Depends on spq_pkg, spq_ctrl, spq_dp.
//
// Usage:
//   A command (cmd, doc_id, prio) transfers on a rising edge with start high
//   and busy low. Its one result (status_code, out_id, out_prio, occupancy)
//   is shown for exactly one cycle with done high; the receiver takes it
//   then and cannot stall the block.
//   Insert, pop and query: the transfer registers the command; in S_EXEC
//   all cells compare and shift in parallel, and done is registered from it.
//   Remove: on an empty queue likewise; else S_SCAN follows S_EXEC and the
//   head cell is examined once per cycle, each held entry once, and
//   rotated to the tail or dropped, so the row keeps its order.
//   One command at a time: busy is high from the transfer until the cycle in
//   which done shows, and a new command may transfer in that cycle.
//   occupancy follows the entry count at all times, mod 32.
//   Reset: synchronous rst empties the queue, clears done and busy.
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  cmd,
  input  logic [15:0] doc_id,
  input  logic [7:0]  prio,
  output logic        busy,
  output logic        done,
  output logic [1:0]  status_code,
  output logic [15:0] out_id,
  output logic [7:0]  out_prio,
  output logic [4:0]  occupancy
);

  ctl_t ctl;
  sts_t sts;

  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  spq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .cmd         (cmd),
    .doc_id      (doc_id),
    .prio        (prio),
    .sts         (sts),
    .done        (done),
    .status_code (status_code),
    .out_id      (out_id),
    .out_prio    (out_prio),
    .occupancy   (occupancy)
  );

endmodule

### rtl/core/spq_chk.sv
// spq_chk: port-level checks for stable_priority_queue, bound to the top.
// Depends on spq_pkg.
module spq_chk
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status_code,
  input logic [15:0] out_id,
  input logic [7:0]  out_prio,
  input logic [4:0]  occupancy
);

  a_transfer_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("transfer did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("done outside the end of a command");

  a_id_only_ok: assert property (@(posedge clk) disable iff (rst)
    done && (out_id != 16'd0 || out_prio != 8'd0) |-> status_code == ST_OK)
    else $error("head entry returned with error status");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && status_code == ST_FULL |-> occupancy == 5'(QUEUE_DEPTH))
    else $error("full reported below depth");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    done && status_code == ST_EMPTY |-> occupancy == 5'd0)
    else $error("empty reported with entries held");

endmodule

bind stable_priority_queue spq_chk #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_chk (.*);

### tb/stable_priority_queue_tb.sv
`timescale 1ns / 1ps
// stable_priority_queue_tb: self-checking bench for the sorted priority queue.
// A directed table, a fill to full, then random bursts; lit rows check against
// literals, the rest a queue model. Depends on spq_pkg, stable_priority_queue.
module stable_priority_queue_tb;
  import spq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int RAND_ITEMS = 950;
  localparam int DRAIN_LIMIT = 400;

  typedef struct packed {
    status_t     st;
    logic [15:0] id;
    logic [7:0]  pr;
    logic [4:0]  occ;
  } result_t;

  typedef struct packed {
    cmd_t        op;
    logic [15:0] id;
    logic [7:0]  pr;
    logic        lit;
    result_t     res;
  } row_t;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  cmd_t        cmd;
  logic [15:0] doc_id;
  logic [7:0]  prio;
  logic        busy;
  logic        done;
  logic [1:0]  status_code;
  logic [15:0] out_id;
  logic [7:0]  out_prio;
  logic [4:0]  occupancy;

  // behavioral copy of the queue
  logic [15:0] held_id [QUEUE_DEPTH];
  logic [7:0]  held_prio [QUEUE_DEPTH];
  int          held_count = 0;
  int          peak_count = 0;

  result_t     pending_results [$];
  bit          row_lit = 1'b0;
  result_t     row_lit_res = '0;
  int          errors = 0;
  int          cmd_seen [4] = '{0, 0, 0, 0};
  int          status_seen [4] = '{0, 0, 0, 0};

  row_t dir_rows [15] = '{
    '{CMD_POP,    16'hFFFF, 8'hFF, 1'b1, '{ST_EMPTY,    16'h0000, 8'h00, 5'd0}},
    '{CMD_QUERY,  16'h0000, 8'h00, 1'b1, '{ST_NOTFOUND, 16'h0000, 8'h00, 5'd0}},
    '{CMD_REMOVE, 16'hFFFF, 8'hFF, 1'b1, '{ST_NOTFOUND, 16'h0000, 8'h00, 5'd0}},
    '{CMD_INSERT, 16'hFFFF, 8'hFF, 1'b1, '{ST_OK,       16'h0000, 8'h00, 5'd1}},
    '{CMD_INSERT, 16'h0000, 8'h00, 1'b1, '{ST_OK,       16'h0000, 8'h00, 5'd2}},
    '{CMD_INSERT, 16'h1234, 8'h80, 1'b1, '{ST_OK,       16'h0000, 8'h00, 5'd3}},
    '{CMD_INSERT, 16'h1234, 8'h80, 1'b1, '{ST_OK,       16'h0000, 8'h00, 5'd4}},
    '{CMD_INSERT, 16'h5555, 8'h80, 1'b1, '{ST_OK,       16'h0000, 8'h00, 5'd5}},
    '{CMD_QUERY,  16'h1234, 8'hFF, 1'b1, '{ST_OK,       16'h0000, 8'h00, 5'd5}},
    '{CMD_QUERY,  16'hAAAA, 8'h00, 1'b1, '{ST_NOTFOUND, 16'h0000, 8'h00, 5'd5}},
    '{CMD_POP,    16'h5A5A, 8'hA5, 1'b1, '{ST_OK,       16'h0000, 8'h00, 5'd4}},
    '{CMD_REMOVE, 16'h1234, 8'h00, 1'b1, '{ST_OK,       16'h0000, 8'h00, 5'd2}},
    '{CMD_REMOVE, 16'h1234, 8'h00, 1'b1, '{ST_NOTFOUND, 16'h0000, 8'h00, 5'd2}},
    '{CMD_POP,    16'h0000, 8'h00, 1'b1, '{ST_OK,       16'h5555, 8'h80, 5'd1}},
    '{CMD_INSERT, 16'h8001, 8'h7F, 1'b0, '{ST_OK,       16'h0000, 8'h00, 5'd0}}
  };

  stable_priority_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .doc_id(doc_id),
    .prio(prio),
    .busy(busy),
    .done(done),
    .status_code(status_code),
    .out_id(out_id),
    .out_prio(out_prio),
    .occupancy(occupancy)
  );

  always #1 clk = ~clk;

  function automatic result_t serve_cmd(cmd_t op, logic [15:0] id, logic [7:0] pr);
    result_t r;
    int pos;
    int i;
    int wr;
    r = '0;
    r.st = ST_OK;
    case (op)
      CMD_INSERT: begin
        if (held_count >= QUEUE_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          pos = 0;
          while (pos < held_count && held_prio[pos] <= pr) pos++;
          for (i = held_count; i > pos; i--) begin
            held_id[i] = held_id[i-1];
            held_prio[i] = held_prio[i-1];
          end
          held_id[pos] = id;
          held_prio[pos] = pr;
          held_count++;
        end
      end
      CMD_POP: begin
        if (held_count == 0) begin
          r.st = ST_EMPTY;
        end else begin
          r.id = held_id[0];
          r.pr = held_prio[0];
          for (i = 1; i < held_count; i++) begin
            held_id[i-1] = held_id[i];
            held_prio[i-1] = held_prio[i];
          end
          held_count--;
        end
      end
      CMD_QUERY: begin
        r.st = ST_NOTFOUND;
        for (i = 0; i < held_count; i++)
          if (held_id[i] == id) r.st = ST_OK;
      end
      default: begin
        wr = 0;
        for (i = 0; i < held_count; i++) begin
          if (held_id[i] != id) begin
            held_id[wr] = held_id[i];
            held_prio[wr] = held_prio[i];
            wr++;
          end
        end
        r.st = (wr == held_count) ? ST_NOTFOUND : ST_OK;
        held_count = wr;
      end
    endcase
    r.occ = 5'(held_count);
    if (held_count > peak_count) peak_count = held_count;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch_results
    result_t want;
    result_t pred;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, expected none, actual status %0d id %h",
                   $time, status_code, out_id);
        end else begin
          want = pending_results.pop_front();
          check_field("status_code", 32'(want.st), 32'(status_code));
          check_field("out_id", 32'(want.id), 32'(out_id));
          check_field("out_prio", 32'(want.pr), 32'(out_prio));
          check_field("occupancy", 32'(want.occ), 32'(occupancy));
        end
      end
      if (start && !busy) begin
        pred = serve_cmd(cmd, doc_id, prio);
        cmd_seen[cmd]++;
        status_seen[pred.st]++;
        pending_results.push_back(row_lit ? row_lit_res : pred);
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send(cmd_t op, logic [15:0] id, logic [7:0] pr, bit lit, result_t res);
    start = 1'b1;
    cmd = op;
    doc_id = id;
    prio = pr;
    row_lit = lit;
    row_lit_res = res;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic idle(int n);
    repeat (n) begin
      start = 1'b0;
      cmd = cmd_t'($urandom_range(0, 3));
      doc_id = 16'($urandom);
      prio = 8'($urandom);
      @(negedge clk);
    end
  endtask

  function automatic cmd_t pick_cmd(phase_t ph);
    int r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL:  return (r < 60) ? CMD_INSERT : (r < 72) ? CMD_POP :
                       (r < 86) ? CMD_QUERY : CMD_REMOVE;
      PH_DRAIN: return (r < 18) ? CMD_INSERT : (r < 75) ? CMD_POP :
                       (r < 88) ? CMD_QUERY : CMD_REMOVE;
      default:  return (r < 30) ? CMD_INSERT : (r < 55) ? CMD_POP :
                       (r < 78) ? CMD_QUERY : CMD_REMOVE;
    endcase
  endfunction

  function automatic logic [15:0] pick_id();
    if (held_count > 0 && $urandom_range(0, 1) == 1)
      return held_id[$urandom_range(0, held_count - 1)];
    if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 7));
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_prio();
    if ($urandom_range(0, 1) == 1) return 8'($urandom_range(0, 3));
    return 8'($urandom);
  endfunction

  initial begin
    #400000;
    $display("stable_priority_queue_tb: errors");
    $finish;
  end

  initial begin : stimulus
    int sent;
    int burst;
    int phase_left;
    int waited;
    phase_t phase;
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_INSERT;
    doc_id = '0;
    prio = '0;
    sent = 0;
    phase_left = 0;
    phase = PH_MIX;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[k]) begin
      send(dir_rows[k].op, dir_rows[k].id, dir_rows[k].pr, dir_rows[k].lit, dir_rows[k].res);
      if (k % 4 == 3) idle($urandom_range(1, 3));
    end
    while (held_count < QUEUE_DEPTH)
      send(CMD_INSERT, 16'($urandom), pick_prio(), 1'b0, '0);
    send(CMD_INSERT, 16'h7FFF, 8'h00, 1'b1, '{ST_FULL, 16'h0, 8'h0, 5'(QUEUE_DEPTH)});

    while (sent < RAND_ITEMS) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      repeat (burst) begin
        if (phase_left == 0) begin
          phase = phase_t'($urandom_range(0, 2));
          phase_left = $urandom_range(20, 60);
        end
        phase_left--;
        send(pick_cmd(phase), pick_id(), pick_prio(), 1'b0, '0);
        sent++;
      end
      idle($urandom_range(1, 8));
    end

    waited = 0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (QUEUE_DEPTH + 8) @(posedge clk);
    @(negedge clk);
    if (pending_results.size() != 0) begin
      errors += pending_results.size();
      $display("%0t: results missing, expected %0d more, actual 0",
               $time, pending_results.size());
    end

    $display("covered %0d inserts, %0d pops, %0d queries, %0d removes; peak depth %0d",
             cmd_seen[CMD_INSERT], cmd_seen[CMD_POP], cmd_seen[CMD_QUERY],
             cmd_seen[CMD_REMOVE], peak_count);
    $display("outcomes: %0d full drops, %0d empty pops, %0d id misses; %0d mismatches",
             status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_NOTFOUND], errors);
    if (errors == 0) begin
      $display("stable_priority_queue_tb: clean");
    end else begin
      $display("stable_priority_queue_tb: errors");
    end
    $finish;
  end

endmodule
